>>> rtl/indexed_deque_store_macros.svh
// Assertion macros shared by the indexed deque store RTL.
`ifndef INDEXED_DEQUE_STORE_MACROS_SVH
`define INDEXED_DEQUE_STORE_MACROS_SVH

// Checks a property in the same cycle; the module must have clk_i and rst_ni.
`define IDQ_ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Checks a property in the cycle after the precondition.
`define IDQ_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/idq_pkg.sv
// Types and codes shared by the indexed deque store modules.
package idq_pkg;

  localparam int unsigned TYPE_W = 3;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCC_W  = 9;

  localparam logic [TYPE_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_READ       = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_WRITE      = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_REMOVE     = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] word_in;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] word_out;
    logic [STAT_W-1:0] status;
    logic [OCC_W-1:0]  occupancy;
  } res_t;

endpackage

>>> rtl/idq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module idq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/idq_addr.sv
// Maps a logical element index to a physical slot of the circular buffer.
module idq_addr #(
  parameter int unsigned DEPTH = 256
) (
  input  logic [$clog2(DEPTH)-1:0] head_i,
  input  logic [$clog2(DEPTH)-1:0] off_i,
  output logic [$clog2(DEPTH)-1:0] phys_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [AW:0] sum;

  // Both operands stay below DEPTH, so one conditional subtract wraps the sum.
  assign sum    = {1'b0, head_i} + {1'b0, off_i};
  assign phys_o = (sum >= (AW+1)'(DEPTH)) ? AW'(sum - (AW+1)'(DEPTH)) : AW'(sum);

endmodule

>>> rtl/indexed_deque_store.sv
// Top level of the indexed deque store: request sequencer around one slot RAM.
//
// An ordered sequence of up to DEPTH words kept in a circular buffer in one RAM.
// A request on req_i is taken at a rising edge where start is high and busy is
// low; busy then stays high until the request's result has been produced.
// Each request yields one result on res_o, marked by done_o for exactly one
// cycle; the receiver must take it then, there is no back pressure.
// Steps from acceptance until the next request can be accepted:
//   push, write, rejected requests and the unused code: S_EXEC
//   pop front, pop back, read: S_EXEC, then S_WAIT for the registered RAM read
//   remove at index: S_EXEC, S_TAKE, then one S_SHIFT per element behind the
//   removed one, since the gap is closed by moving one element per cycle
//   through the RAM's read and write ports.
// The result of one request may still be on res_o while the next is accepted.
// res_o.occupancy shows the element count after the request.
// Reset empties the store at once (head and count cleared); slot contents are
// not cleared and are only read below the count, so no clearing pass is needed.
`include "indexed_deque_store_macros.svh"

module indexed_deque_store
  import idq_pkg::*;
#(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output res_t res_o
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_TAKE,
    S_SHIFT
  } state_e;

  state_e            state_q;
  req_t              req_q;
  logic [AW-1:0]     head_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  k_q;
  logic              done_q;
  logic [WORD_W-1:0] word_q;
  logic [STAT_W-1:0] status_q;

  logic                 full;
  logic                 empty;
  logic                 pos_bad;
  logic                 more_take;
  logic                 more_shift;
  logic [AW-1:0]        hd_dec;
  logic [AW-1:0]        hd_inc;
  logic [CNT_W-1:0]     rd_off;
  logic [CNT_W-1:0]     wr_off;
  logic [AW-1:0]        rd_phys;
  logic [AW-1:0]        wr_phys;
  logic                 ram_we;
  logic                 ram_re;
  logic                 wr_at_head;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  assign busy = (state_q != S_IDLE);

  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);
  assign pos_bad    = (CMP_W'(req_q.position) >= CMP_W'(count_q));
  assign more_take  = ((k_q + CNT_W'(1)) < count_q);
  assign more_shift = ((k_q + CNT_W'(2)) < count_q);
  assign hd_dec     = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
  assign hd_inc     = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

  // RAM port control. During a removal the element at k+2 (k+1 in S_TAKE) is read
  // while the one read in the previous cycle is written at k, one place toward the front.
  always_comb begin
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    wr_at_head = 1'b0;
    rd_off     = '0;
    wr_off     = '0;
    ram_wdata  = req_q.word_in[WORD_BITS-1:0];
    unique case (state_q)
      S_EXEC: begin
        unique case (req_q.req_type)
          REQ_PUSH_FRONT: begin
            ram_we     = !full;
            wr_at_head = 1'b1;
          end
          REQ_PUSH_BACK: begin
            ram_we = !full;
            wr_off = count_q;
          end
          REQ_POP_FRONT: begin
            ram_re = !empty;
          end
          REQ_POP_BACK: begin
            ram_re = !empty;
            rd_off = count_q - CNT_W'(1);
          end
          REQ_READ, REQ_REMOVE: begin
            ram_re = !pos_bad;
            rd_off = CNT_W'(req_q.position);
          end
          REQ_WRITE: begin
            ram_we = !pos_bad;
            wr_off = CNT_W'(req_q.position);
          end
          default: begin
          end
        endcase
      end
      S_TAKE: begin
        ram_re = more_take;
        rd_off = k_q + CNT_W'(1);
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        wr_off    = k_q;
        ram_wdata = ram_rdata;
        ram_re    = more_shift;
        rd_off    = k_q + CNT_W'(2);
      end
      default: begin
      end
    endcase
  end

  assign ram_waddr = wr_at_head ? hd_dec : wr_phys;

  idq_addr #(
    .DEPTH (DEPTH)
  ) u_rd_addr (
    .head_i (head_q),
    .off_i  (AW'(rd_off)),
    .phys_o (rd_phys)
  );

  idq_addr #(
    .DEPTH (DEPTH)
  ) u_wr_addr (
    .head_i (head_q),
    .off_i  (AW'(wr_off)),
    .phys_o (wr_phys)
  );

  idq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_phys),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      k_q      <= '0;
      done_q   <= 1'b0;
      word_q   <= '0;
      status_q <= ST_OK;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q  <= S_IDLE;
          done_q   <= 1'b1;
          word_q   <= '0;
          status_q <= ST_OK;
          unique case (req_q.req_type)
            REQ_PUSH_FRONT: begin
              if (full) begin
                status_q <= ST_FULL;
              end else begin
                head_q  <= hd_dec;
                count_q <= count_q + CNT_W'(1);
              end
            end
            REQ_PUSH_BACK: begin
              if (full) begin
                status_q <= ST_FULL;
              end else begin
                count_q <= count_q + CNT_W'(1);
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
              if (empty) begin
                status_q <= ST_EMPTY;
              end else begin
                state_q <= S_WAIT;
                done_q  <= 1'b0;
              end
            end
            REQ_READ: begin
              if (pos_bad) begin
                status_q <= ST_RANGE;
              end else begin
                state_q <= S_WAIT;
                done_q  <= 1'b0;
              end
            end
            REQ_WRITE: begin
              if (pos_bad) begin
                status_q <= ST_RANGE;
              end
            end
            REQ_REMOVE: begin
              if (pos_bad) begin
                status_q <= ST_RANGE;
              end else begin
                k_q     <= CNT_W'(req_q.position);
                state_q <= S_TAKE;
                done_q  <= 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        S_WAIT: begin
          state_q  <= S_IDLE;
          done_q   <= 1'b1;
          word_q   <= WORD_W'(ram_rdata);
          status_q <= ST_OK;
          if (req_q.req_type == REQ_POP_FRONT) begin
            head_q  <= hd_inc;
            count_q <= count_q - CNT_W'(1);
          end else if (req_q.req_type == REQ_POP_BACK) begin
            count_q <= count_q - CNT_W'(1);
          end
        end
        S_TAKE: begin
          word_q   <= WORD_W'(ram_rdata);
          status_q <= ST_OK;
          if (more_take) begin
            state_q <= S_SHIFT;
          end else begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
            count_q <= count_q - CNT_W'(1);
          end
        end
        S_SHIFT: begin
          k_q <= k_q + CNT_W'(1);
          if (!more_shift) begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
            count_q <= count_q - CNT_W'(1);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // The count only changes while busy, so it is stable while a result is shown.
  assign done_o          = done_q;
  assign res_o.word_out  = word_q;
  assign res_o.status    = status_q;
  assign res_o.occupancy = OCC_W'(count_q);

  `IDQ_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "count exceeds depth")
  `IDQ_ASSERT_NEXT(a_done_single, done_q, !done_q, "result strobe lasted two cycles")
  `IDQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done_q, "accepted request not busy")
  `IDQ_ASSERT_SAME(a_err_word, done_q && status_q != ST_OK, word_q == '0, "error with data")
  `IDQ_ASSERT_SAME(a_full_count, done_q && status_q == ST_FULL, full, "full status when not full")

endmodule

>>> tb/indexed_deque_store_test.sv
// Self-checking testbench for the indexed deque store, with its own predictor, driver and monitor.
module indexed_deque_store_test;
  import idq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = 256;
  localparam int unsigned WORD_BITS    = 64;
  localparam logic [WORD_W-1:0] WORD_MASK = {WORD_W{1'b1}} >> (WORD_W - WORD_BITS);
  localparam logic [TYPE_W-1:0] REQ_UNUSED = 3'd7;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned PRINT_LIMIT  = 50;

  typedef struct {
    req_t req;
    bit   settle;
  } queued_req_t;

  logic clk_i;
  logic rst_ni  = 1'b0;
  logic start   = 1'b0;
  req_t req_bus = '0;
  logic busy;
  logic done_o;
  res_t res_o;

  indexed_deque_store #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WORD_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_bus),
    .done_o(done_o),
    .res_o (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("[indexed_deque_store] ERROR");
    $finish;
  end

  // Predictor state: circular buffer with front slot and element count.
  logic [WORD_W-1:0] deque_mem [DEPTH];
  int unsigned front_slot = 0;
  int unsigned fill_level = 0;

  queued_req_t pending_reqs[$];
  res_t        expected_results[$];

  int unsigned mismatch_count = 0;
  int unsigned checked_count  = 0;
  int unsigned full_hits      = 0;
  int unsigned empty_hits     = 0;
  int unsigned range_hits     = 0;
  int unsigned removals       = 0;
  int unsigned peak_level     = 0;

  // Count as the stimulus generator expects it, used only to aim indices.
  int unsigned planned_count = 0;
  int unsigned random_total  = 0;

  int unsigned idle_left  = 0;
  int unsigned burst_left = 8;

  function automatic int unsigned slot_of(input int unsigned logical);
    return (front_slot + logical) % DEPTH;
  endfunction

  function automatic res_t apply_request(input req_t r);
    res_t        o;
    logic [WORD_W-1:0] w;
    int unsigned i;
    o        = '0;
    o.status = ST_OK;
    w        = r.word_in & WORD_MASK;
    case (r.req_type)
      REQ_PUSH_FRONT: begin
        if (fill_level >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          front_slot = (front_slot + DEPTH - 1) % DEPTH;
          deque_mem[front_slot] = w;
          fill_level++;
        end
      end
      REQ_PUSH_BACK: begin
        if (fill_level >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          deque_mem[slot_of(fill_level)] = w;
          fill_level++;
        end
      end
      REQ_POP_FRONT: begin
        if (fill_level == 0) begin
          o.status = ST_EMPTY;
        end else begin
          o.word_out = deque_mem[front_slot];
          front_slot = (front_slot + 1) % DEPTH;
          fill_level--;
        end
      end
      REQ_POP_BACK: begin
        if (fill_level == 0) begin
          o.status = ST_EMPTY;
        end else begin
          o.word_out = deque_mem[slot_of(fill_level - 1)];
          fill_level--;
        end
      end
      REQ_READ: begin
        if (r.position >= fill_level) o.status = ST_RANGE;
        else o.word_out = deque_mem[slot_of(r.position)];
      end
      REQ_WRITE: begin
        if (r.position >= fill_level) o.status = ST_RANGE;
        else deque_mem[slot_of(r.position)] = w;
      end
      REQ_REMOVE: begin
        if (r.position >= fill_level) begin
          o.status = ST_RANGE;
        end else begin
          o.word_out = deque_mem[slot_of(r.position)];
          // Later elements each move one place toward the front.
          for (i = r.position; i + 1 < fill_level; i++) begin
            deque_mem[slot_of(i)] = deque_mem[slot_of(i + 1)];
          end
          fill_level--;
          removals++;
        end
      end
      default: begin
      end
    endcase
    o.word_out  = o.word_out & WORD_MASK;
    o.occupancy = OCC_W'(fill_level);
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    end
  endtask

  // Driver: presents queued requests in bursts separated by random idle gaps.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_results.push_back(apply_request(req_bus));
      end
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].settle && expected_results.size() != 0)) begin
          req_bus <= pending_reqs[0].req;
          start   <= 1'b1;
          pending_reqs.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(20, 60);
            idle_left  = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            idle_left  = $urandom_range(1, 9);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request outstanding", res_o.word_out, '0);
      end else begin
        want = expected_results.pop_front();
        checked_count++;
        if (res_o.word_out !== want.word_out)
          report_mismatch("word_out", res_o.word_out, want.word_out);
        if (res_o.status !== want.status)
          report_mismatch("status", WORD_W'(res_o.status), WORD_W'(want.status));
        if (res_o.occupancy !== want.occupancy)
          report_mismatch("occupancy", WORD_W'(res_o.occupancy), WORD_W'(want.occupancy));
        case (want.status)
          ST_FULL:  full_hits++;
          ST_EMPTY: empty_hits++;
          ST_RANGE: range_hits++;
          default: begin
          end
        endcase
        if (want.occupancy > peak_level) peak_level = want.occupancy;
      end
    end
  end

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (planned_count > 0 && r < 8) return POS_W'($urandom_range(0, planned_count - 1));
    if (r == 8 && planned_count < DEPTH) return POS_W'(planned_count);
    return POS_W'($urandom_range(0, 255));
  endfunction

  task automatic queue_req(input logic [TYPE_W-1:0] kind, input logic [POS_W-1:0] pos,
                           input logic [WORD_W-1:0] word, input bit settle);
    queued_req_t q;
    q.req.req_type = kind;
    q.req.position = pos;
    q.req.word_in  = word;
    q.settle       = settle || ($urandom_range(0, 59) == 0);
    pending_reqs.push_back(q);
    case (kind)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: if (planned_count < DEPTH) planned_count++;
      REQ_POP_FRONT, REQ_POP_BACK:   if (planned_count > 0) planned_count--;
      REQ_REMOVE:                    if (pos < planned_count) planned_count--;
      default: begin
      end
    endcase
  endtask

  task automatic queue_random_push();
    queue_req($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
              POS_W'($urandom_range(0, 255)), pick_word(), 1'b0);
    random_total++;
  endtask

  task automatic queue_random_pop();
    queue_req($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK,
              POS_W'($urandom_range(0, 255)), pick_word(), 1'b0);
    random_total++;
  endtask

  task automatic queue_mixed();
    int unsigned r;
    logic [TYPE_W-1:0] kind;
    r = $urandom_range(0, 99);
    if (r < 14)      kind = REQ_PUSH_FRONT;
    else if (r < 28) kind = REQ_PUSH_BACK;
    else if (r < 40) kind = REQ_POP_FRONT;
    else if (r < 52) kind = REQ_POP_BACK;
    else if (r < 66) kind = REQ_READ;
    else if (r < 80) kind = REQ_WRITE;
    else if (r < 98) kind = REQ_REMOVE;
    else             kind = REQ_UNUSED;
    queue_req(kind, pick_position(), pick_word(), 1'b0);
    random_total++;
  endtask

  task automatic queue_drain();
    while (planned_count > 0) queue_random_pop();
    queue_random_pop();
    queue_random_pop();
  endtask

  initial begin
    // Rejections on an empty store, then the unused code.
    queue_req(REQ_POP_FRONT, 8'd0, '1, 1'b0);
    queue_req(REQ_POP_BACK, 8'd255, '0, 1'b0);
    queue_req(REQ_READ, 8'd0, '0, 1'b0);
    queue_req(REQ_WRITE, 8'd0, '1, 1'b0);
    queue_req(REQ_REMOVE, 8'd0, '0, 1'b0);
    queue_req(REQ_REMOVE, 8'd255, '1, 1'b0);
    queue_req(REQ_UNUSED, 8'd255, '1, 1'b0);
    // Removing the only element empties the store.
    queue_req(REQ_PUSH_BACK, 8'd0, '1, 1'b0);
    queue_req(REQ_REMOVE, 8'd0, '0, 1'b0);
    queue_req(REQ_POP_FRONT, 8'd0, '0, 1'b0);
    // A few elements with the head wrapping below slot zero.
    queue_req(REQ_PUSH_FRONT, 8'd0, '0, 1'b0);
    queue_req(REQ_PUSH_BACK, 8'd0, 64'hA5A5_5A5A_0123_4567, 1'b0);
    queue_req(REQ_PUSH_FRONT, 8'd0, '1, 1'b0);
    queue_req(REQ_READ, 8'd3, '0, 1'b0);
    queue_req(REQ_READ, 8'd0, '0, 1'b0);
    queue_req(REQ_WRITE, 8'd1, 64'h8000_0000_0000_0001, 1'b0);
    queue_req(REQ_READ, 8'd1, '0, 1'b0);
    queue_req(REQ_READ, 8'd255, '0, 1'b0);
    queue_req(REQ_WRITE, 8'd255, '1, 1'b0);
    queue_req(REQ_REMOVE, 8'd1, '0, 1'b0);
    queue_req(REQ_READ, 8'd1, '0, 1'b0);
    queue_req(REQ_POP_BACK, 8'd0, '0, 1'b0);
    queue_req(REQ_POP_FRONT, 8'd0, '0, 1'b0);

    // Fill completely, push against a full store, churn, then drain.
    queue_req(REQ_PUSH_BACK, 8'd0, pick_word(), 1'b1);
    while (planned_count < DEPTH) queue_random_push();
    queue_req(REQ_PUSH_FRONT, 8'd0, pick_word(), 1'b0);
    queue_req(REQ_PUSH_BACK, 8'd0, pick_word(), 1'b0);
    repeat (120) queue_mixed();
    queue_drain();
    while (random_total < RANDOM_ITEMS) begin
      repeat ($urandom_range(0, 40)) queue_random_push();
      repeat ($urandom_range(20, 60)) queue_mixed();
      if ($urandom_range(0, 2) == 0) queue_drain();
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || start || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DEPTH + 8) @(posedge clk_i);

    $display("Checked %0d requests, peak occupancy %0d, %0d removals at an index.",
             checked_count, peak_level, removals);
    $display("Rejections seen: %0d full, %0d empty, %0d out of range; %0d mismatches.",
             full_hits, empty_hits, range_hits, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[indexed_deque_store] OK");
    end else begin
      $display("[indexed_deque_store] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/idq_pkg.sv
rtl/idq_ram.sv
rtl/idq_addr.sv
rtl/indexed_deque_store.sv
tb/indexed_deque_store_test.sv
